FILE: sv/point_transform_4x4_macros.svh
// Assertion macros shared by the checker of the point transform block.
`ifndef POINT_TRANSFORM_4X4_MACROS_SVH
`define POINT_TRANSFORM_4X4_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define PTX_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("point_transform_4x4 check failed");

// Clocked assertion that also holds while reset is asserted.
`define PTX_ASSERT_ALWAYS(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("point_transform_4x4 check failed");

`endif

FILE: sv/ptx_pkg.sv
// Package with the shared constants of the point transform block.
`default_nettype none
package ptx_pkg;
	localparam int FRAC_BITS_DEF   = 16;
	localparam int COORD_WIDTH_DEF = 32;
	localparam int COEF_W          = 32;
	localparam int FIELD_W         = 32;
	localparam int REG_W           = 64;
	localparam int NUM_REGS        = 8;
	localparam int REG_IDX_W       = 3;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_ROW0_COLS01 = 3'd0,
		REG_ROW0_COLS23 = 3'd1,
		REG_ROW1_COLS01 = 3'd2,
		REG_ROW1_COLS23 = 3'd3,
		REG_ROW2_COLS01 = 3'd4,
		REG_ROW2_COLS23 = 3'd5,
		REG_ROW3_COLS01 = 3'd6,
		REG_ROW3_COLS23 = 3'd7
	} reg_idx_t;
endpackage
`default_nettype wire

FILE: sv/ptx_div_stage.sv
// One restoring division step for the three coordinate lanes, registered.
`default_nettype none
module ptx_div_stage #(
	parameter int DW  = 130,
	parameter int SW  = 50,
	parameter int QW  = 32,
	parameter int MW  = 105,
	parameter int BIT = 0
) (
	input  wire logic                   clk,
	input  wire logic                   en,
	input  wire logic [2:0][DW-1:0]     rem_i,
	input  wire logic [2:0][QW-1:0]     q_i,
	input  wire logic [SW-1:0]          ud_i,
	input  wire logic [MW-1:0]          meta_i,
	output logic      [2:0][DW-1:0]     rem_o,
	output logic      [2:0][QW-1:0]     q_o,
	output logic      [SW-1:0]          ud_o,
	output logic      [MW-1:0]          meta_o
);
	logic [DW-1:0]          dsh;
	logic [2:0][DW-1:0]     rem_s1;
	logic [2:0][QW-1:0]     q_s1;
	logic [SW-1:0]          ud_s1;
	logic [MW-1:0]          meta_s1;
	logic [2:0][DW-1:0]     rem_n;
	logic [2:0][QW-1:0]     q_n;

	assign dsh = DW'(ud_i) << BIT;

	always_comb begin
		for (int l = 0; l < 3; l++) begin
			rem_n[l] = rem_i[l];
			q_n[l]   = q_i[l];
			if (rem_i[l] >= dsh) begin
				rem_n[l]    = rem_i[l] - dsh;
				q_n[l][BIT] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s1  <= rem_n;
			q_s1    <= q_n;
			ud_s1   <= ud_i;
			meta_s1 <= meta_i;
		end
	end

	assign rem_o  = rem_s1;
	assign q_o    = q_s1;
	assign ud_o   = ud_s1;
	assign meta_o = meta_s1;
endmodule
`default_nettype wire

FILE: sv/point_transform_4x4.sv
// Top level of the pipelined homogeneous 4x4 point transform.
//
// Usage: points arrive on the s_axis stream, one per transaction, with x, y and z
// packed in tdata and the projective-mode flag in tuser. Results leave on the
// m_axis stream with the transformed x, y and z in tdata and the w_zero and
// saturated flags in tuser. The eight matrix registers are written through the
// cfg port; the user must do so only while no point is in flight, as the block
// does not enforce it. Each holds two Q16.16 coefficients. Throughput is one
// point per clock unless the receiver stalls. The pipeline has one stage of
// multipliers, one of row adders, two of sign and range handling, one restoring
// division stage per quotient bit and the output register. The division stages
// run for every point, so affine and projective points have the same latency
// and leave in order. Each stage has its own valid bit and moves whenever the
// stage after it is empty or moving, so a stalled receiver fills the gaps in
// the pipeline before s_axis_tready falls; nothing is dropped or repeated.
// Reset clears all valid bits and loads the identity matrix.
`default_nettype none
module point_transform_4x4 #(
	parameter int FRAC_BITS   = ptx_pkg::FRAC_BITS_DEF,
	parameter int COORD_WIDTH = ptx_pkg::COORD_WIDTH_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_axis_tvalid,
	output logic                               s_axis_tready,
	// tdata: in_x [31:0], in_y [63:32], in_z [95:64]
	input  wire logic [3*ptx_pkg::FIELD_W-1:0] s_axis_tdata,
	// tuser: divide_by_w [0]
	input  wire logic [0:0]                    s_axis_tuser,
	output logic                               m_axis_tvalid,
	input  wire logic                          m_axis_tready,
	// tdata: out_x [31:0], out_y [63:32], out_z [95:64]
	output logic      [3*ptx_pkg::FIELD_W-1:0] m_axis_tdata,
	// tuser: w_zero [0], saturated [1]
	output logic      [1:0]                    m_axis_tuser,
	input  wire logic                          cfg_we,
	input  wire logic [ptx_pkg::REG_IDX_W-1:0] cfg_index,
	input  wire logic [ptx_pkg::REG_W-1:0]     cfg_wdata
);
	import ptx_pkg::*;

	localparam int C    = COORD_WIDTH;
	localparam int PW   = COEF_W + C;          // exact product width
	localparam int SUMW = PW + 2;              // exact four-term sum
	localparam int SW   = SUMW - FRAC_BITS;    // row sum after the floor shift
	localparam int DW   = SW + FRAC_BITS + C;  // divider remainder width
	localparam int MW   = 9 + 3 * C;           // side data through the divider
	localparam int NST  = C + 5;               // number of pipeline stages
	localparam logic [REG_W-1:0] ONE_LO = REG_W'(1) << FRAC_BITS;
	localparam logic [REG_W-1:0] ONE_HI = REG_W'(1) << (COEF_W + FRAC_BITS);
	// Reset value of the matrix registers: the identity matrix.
	localparam logic [NUM_REGS-1:0][REG_W-1:0] MAT_RST =
		{ONE_HI, REG_W'(0), ONE_LO, REG_W'(0), REG_W'(0), ONE_HI, REG_W'(0), ONE_LO};
	localparam logic [C-1:0] MAXV = {1'b0, {(C-1){1'b1}}};
	localparam logic [C-1:0] MINV = {1'b1, {(C-1){1'b0}}};

	// Matrix registers.
	logic [NUM_REGS-1:0][REG_W-1:0] mat_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mat_q <= MAT_RST;
		end else if (cfg_we) begin
			mat_q[cfg_index] <= cfg_wdata;
		end
	end

	// Coefficient view: coef[r][c].
	logic signed [3:0][3:0][COEF_W-1:0] coef;
	always_comb begin
		for (int r = 0; r < 4; r++) begin
			coef[r][0] = mat_q[2*r][COEF_W-1:0];
			coef[r][1] = mat_q[2*r][REG_W-1:COEF_W];
			coef[r][2] = mat_q[2*r+1][COEF_W-1:0];
			coef[r][3] = mat_q[2*r+1][REG_W-1:COEF_W];
		end
	end

	// Valid bits and per-stage enables; a stage loads when it is empty or
	// the stage after it loads.
	logic [NST-1:0] vld_q;
	logic [NST-1:0] en;

	always_comb begin
		en[NST-1] = !vld_q[NST-1] || m_axis_tready;
		for (int k = NST - 2; k >= 0; k--)
			en[k] = !vld_q[k] || en[k+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[0])
				vld_q[0] <= s_axis_tvalid;
			for (int k = 1; k < NST; k++)
				if (en[k])
					vld_q[k] <= vld_q[k-1];
		end
	end

	assign s_axis_tready = en[0];

	// Stage 1: the twelve coordinate products.
	logic signed [2:0][C-1:0]       pt;
	logic signed [3:0][2:0][PW-1:0] prod_s1;
	logic                           mode_s1;

	always_comb begin
		for (int l = 0; l < 3; l++)
			pt[l] = s_axis_tdata[l*FIELD_W +: C];
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			for (int r = 0; r < 4; r++)
				for (int l = 0; l < 3; l++)
					prod_s1[r][l] <= PW'(signed'(coef[r][l])) * PW'(signed'(pt[l]));
			mode_s1 <= s_axis_tuser[0];
		end
	end

	// Stage 2: row sums with the translation term, floor-shifted.
	logic signed [3:0][SUMW-1:0] sum;
	logic signed [3:0][SW-1:0]   rs_s2;
	logic                        mode_s2;

	always_comb begin
		for (int r = 0; r < 4; r++)
			sum[r] = SUMW'(signed'(prod_s1[r][0])) + SUMW'(signed'(prod_s1[r][1]))
				+ SUMW'(signed'(prod_s1[r][2]))
				+ (SUMW'(signed'(coef[r][3])) <<< FRAC_BITS);
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			for (int r = 0; r < 4; r++)
				rs_s2[r] <= sum[r][SUMW-1:FRAC_BITS];
			mode_s2 <= mode_s1;
		end
	end

	// Stage 3: affine clamp, magnitudes and signs for the division.
	logic [2:0][C-1:0]  direct_n;
	logic [2:0]         over, under;
	logic [2:0][SW-1:0] un_n;
	logic [SW-1:0]      ud_n;

	logic [2:0][C-1:0]  direct_s3;
	logic               dsat_s3;
	logic [2:0][SW-1:0] un_s3;
	logic [SW-1:0]      ud_s3;
	logic [2:0]         neg_s3;
	logic               wz_s3;
	logic               mode_s3;

	always_comb begin
		for (int l = 0; l < 3; l++) begin
			over[l]  = !rs_s2[l][SW-1] && (|rs_s2[l][SW-2:C-1]);
			under[l] = rs_s2[l][SW-1] && !(&rs_s2[l][SW-2:C-1]);
			if (over[l])
				direct_n[l] = MAXV;
			else if (under[l])
				direct_n[l] = MINV;
			else
				direct_n[l] = rs_s2[l][C-1:0];
			un_n[l] = rs_s2[l][SW-1] ? (SW'(0) - rs_s2[l]) : rs_s2[l];
		end
		ud_n = rs_s2[3][SW-1] ? (SW'(0) - rs_s2[3]) : rs_s2[3];
	end

	always_ff @(posedge clk) begin
		if (en[2]) begin
			direct_s3 <= direct_n;
			dsat_s3   <= |(over | under);
			un_s3     <= un_n;
			ud_s3     <= ud_n;
			for (int l = 0; l < 3; l++)
				neg_s3[l] <= rs_s2[l][SW-1] ^ rs_s2[3][SW-1];
			wz_s3     <= (rs_s2[3] == '0);
			mode_s3   <= mode_s2;
		end
	end

	// Stage 4: overflow test of the quotient and divider start values.
	// A quotient of 2**C or more is saturated whatever its low bits are.
	logic [2:0][DW-1:0] rem_s4;
	logic [2:0]         big_s4;
	logic [SW-1:0]      ud_s4;
	logic [2:0][C-1:0]  direct_s4;
	logic               dsat_s4;
	logic [2:0]         neg_s4;
	logic               wz_s4;
	logic               mode_s4;

	always_ff @(posedge clk) begin
		if (en[3]) begin
			for (int l = 0; l < 3; l++) begin
				rem_s4[l] <= DW'(un_s3[l]) << FRAC_BITS;
				big_s4[l] <= (DW'(un_s3[l]) << FRAC_BITS) >= (DW'(ud_s3) << C);
			end
			ud_s4     <= ud_s3;
			direct_s4 <= direct_s3;
			dsat_s4   <= dsat_s3;
			neg_s4    <= neg_s3;
			wz_s4     <= wz_s3;
			mode_s4   <= mode_s3;
		end
	end

	// Division stages, one quotient bit each, most significant first.
	logic [2:0][DW-1:0] div_rem  [0:C];
	logic [2:0][C-1:0]  div_q    [0:C];
	logic [SW-1:0]      div_ud   [0:C];
	logic [MW-1:0]      div_meta [0:C];

	assign div_rem[0]  = rem_s4;
	assign div_q[0]    = '0;
	assign div_ud[0]   = ud_s4;
	assign div_meta[0] = {dsat_s4, direct_s4, big_s4, neg_s4, wz_s4, mode_s4};

	for (genvar k = 0; k < C; k++) begin : g_div
		ptx_div_stage #(
			.DW  (DW),
			.SW  (SW),
			.QW  (C),
			.MW  (MW),
			.BIT (C - 1 - k)
		) u_stage (
			.clk    (clk),
			.en     (en[4+k]),
			.rem_i  (div_rem[k]),
			.q_i    (div_q[k]),
			.ud_i   (div_ud[k]),
			.meta_i (div_meta[k]),
			.rem_o  (div_rem[k+1]),
			.q_o    (div_q[k+1]),
			.ud_o   (div_ud[k+1]),
			.meta_o (div_meta[k+1])
		);
	end

	// Stage 5: sign, saturation and mode selection into the output register.
	logic              f_mode, f_wz, f_dsat;
	logic [2:0]        f_neg, f_big, qsat;
	logic [2:0][C-1:0] f_direct, lim, mag, res;
	logic [3*FIELD_W-1:0] data_n;

	assign {f_dsat, f_direct, f_big, f_neg, f_wz, f_mode} = div_meta[C];

	always_comb begin
		for (int l = 0; l < 3; l++) begin
			lim[l]  = f_neg[l] ? MINV : MAXV;
			qsat[l] = f_big[l] || (div_q[C][l] > lim[l]);
			mag[l]  = qsat[l] ? lim[l] : div_q[C][l];
			if (!f_mode)
				res[l] = f_direct[l];
			else if (f_wz)
				res[l] = '0;
			else
				res[l] = f_neg[l] ? (C'(0) - mag[l]) : mag[l];
			data_n[l*FIELD_W +: FIELD_W] = FIELD_W'(signed'(res[l]));
		end
	end

	logic [3*FIELD_W-1:0] data_s5;
	logic [1:0]           user_s5;

	always_ff @(posedge clk) begin
		if (en[NST-1]) begin
			data_s5    <= data_n;
			user_s5[0] <= f_mode && f_wz;
			user_s5[1] <= f_mode ? (!f_wz && (|qsat)) : f_dsat;
		end
	end

	assign m_axis_tvalid = vld_q[NST-1];
	assign m_axis_tdata  = data_s5;
	assign m_axis_tuser  = user_s5;
endmodule
`default_nettype wire

FILE: sv/ptx_chk.sv
// Port-level checker of the point transform block and its bind statement.
`default_nettype none
`include "point_transform_4x4_macros.svh"
module ptx_chk (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_axis_tready,
	input wire logic        m_axis_tvalid,
	input wire logic        m_axis_tready,
	input wire logic [95:0] m_axis_tdata,
	input wire logic [1:0]  m_axis_tuser
);
	// A pending result transaction is not withdrawn.
	`PTX_ASSERT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
	// A zero divisor gives zero coordinates and no saturation.
	`PTX_ASSERT(a_wzero, clk, arst_n, m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == '0 && !m_axis_tuser[1])
	// A receiver that takes results never blocks the input side.
	`PTX_ASSERT(a_flow, clk, arst_n, m_axis_tready |-> s_axis_tready)
	// No result is offered while reset is held.
	`PTX_ASSERT_ALWAYS(a_rst, clk, !arst_n |-> !m_axis_tvalid)
endmodule

bind point_transform_4x4 ptx_chk u_ptx_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);
`default_nettype wire
